### hw/rtl/card_number_luhn_validator_assert.svh
// Assertion helpers for the card number checker.
`ifndef CARD_NUMBER_LUHN_VALIDATOR_ASSERT_SVH
`define CARD_NUMBER_LUHN_VALIDATOR_ASSERT_SVH

`ifndef SYNTHESIS
// Checked only out of reset.
`define CLV_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked at every edge, reset included.
`define CLV_ASSERT_ANY(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CLV_ASSERT_RST(lbl, clk, rstn, prop, msg)
`define CLV_ASSERT_ANY(lbl, clk, prop, msg)
`endif

`endif

### hw/rtl/clv_pkg.sv
`default_nettype none

package clv_pkg;

    localparam int CHAR_W  = 8;
    localparam int COUNT_W = 5;
    localparam int DIGIT_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;
    localparam logic [COUNT_W-1:0] MIN_DIGITS_RESET = 5'd13;
    localparam logic [COUNT_W-1:0] MAX_DIGITS_RESET = 5'd19;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX = 2'd1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
    localparam logic [1:0] STATUS_BAD_LEN  = 2'd2;
    localparam logic [1:0] STATUS_BAD_SUM  = 2'd3;

    localparam logic [2:0] CLASS_OTHER    = 3'd0;
    localparam logic [2:0] CLASS_FOUR     = 3'd1;
    localparam logic [2:0] CLASS_FIVE     = 3'd2;
    localparam logic [2:0] CLASS_SIX      = 3'd3;
    localparam logic [2:0] CLASS_THREE    = 3'd4;
    localparam logic [2:0] CLASS_THREE_47 = 3'd5;

    typedef struct packed {
        logic [COUNT_W-1:0] min_digits;
        logic [COUNT_W-1:0] max_digits;
    } cfg_t;

    // status sits in the low bits
    typedef struct packed {
        logic [COUNT_W-1:0] digit_total;
        logic [2:0]         prefix_class;
        logic [1:0]         status;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    function automatic logic [DIGIT_W-1:0] add_mod10(input logic [DIGIT_W-1:0] a,
                                                     input logic [DIGIT_W-1:0] b);
        logic [DIGIT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= 5'd10) ? 4'(s - 5'd10) : s[DIGIT_W-1:0];
    endfunction

    function automatic logic [DIGIT_W-1:0] doubled(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W:0] t;
        t = {d, 1'b0};
        return (t > 5'd9) ? 4'(t - 5'd9) : t[DIGIT_W-1:0];
    endfunction

    function automatic logic [2:0] classify(input logic [DIGIT_W-1:0] first,
                                            input logic [DIGIT_W-1:0] second);
        logic [2:0] cls;
        case (first)
            4'd3:    cls = (second == 4'd4 || second == 4'd7) ? CLASS_THREE_47 : CLASS_THREE;
            4'd4:    cls = CLASS_FOUR;
            4'd5:    cls = CLASS_FIVE;
            4'd6:    cls = CLASS_SIX;
            default: cls = CLASS_OTHER;
        endcase
        return cls;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/clv_accum.sv
`default_nettype none

// Running digit count, prefix digits and the two parity Luhn sums.
module clv_accum (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           take,
    input  wire logic [clv_pkg::CHAR_W-1:0]     char_code,
    input  wire logic                           is_final,
    input  wire clv_pkg::cfg_t                  cfg,
    output logic                                push,
    output clv_pkg::result_t                    result
);

    logic [clv_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [clv_pkg::DIGIT_W-1:0] sum_even_reg, sum_even_next;
    logic [clv_pkg::DIGIT_W-1:0] sum_odd_reg, sum_odd_next;
    logic [clv_pkg::DIGIT_W-1:0] first_reg, first_next;
    logic [clv_pkg::DIGIT_W-1:0] second_reg, second_next;
    logic                        bad_reg, bad_next;

    logic                        is_digit;
    logic [clv_pkg::DIGIT_W-1:0] d;

    assign is_digit = (char_code >= clv_pkg::CHAR_ZERO) && (char_code <= clv_pkg::CHAR_NINE);
    assign d        = char_code[clv_pkg::DIGIT_W-1:0];

    always_comb begin
        count_next    = count_reg;
        sum_even_next = sum_even_reg;
        sum_odd_next  = sum_odd_reg;
        first_next    = first_reg;
        second_next   = second_reg;
        bad_next      = bad_reg;
        if (is_digit) begin
            // a new digit flips the parity of what is still to come
            sum_even_next = clv_pkg::add_mod10(sum_odd_reg, d);
            sum_odd_next  = clv_pkg::add_mod10(sum_even_reg, clv_pkg::doubled(d));
            if (count_reg == '0) begin
                first_next = d;
            end
            if (count_reg == 5'd1) begin
                second_next = d;
            end
            if (count_reg != clv_pkg::COUNT_MAX) begin
                count_next = count_reg + 5'd1;
            end
        end else if (char_code != clv_pkg::CHAR_SPACE) begin
            bad_next = 1'b1;
        end
    end

    always_comb begin
        if (bad_next) begin
            result.status = clv_pkg::STATUS_BAD_CHAR;
        end else if (count_next < cfg.min_digits || count_next > cfg.max_digits) begin
            result.status = clv_pkg::STATUS_BAD_LEN;
        end else if (sum_even_next != '0) begin
            result.status = clv_pkg::STATUS_BAD_SUM;
        end else begin
            result.status = clv_pkg::STATUS_OK;
        end
        result.prefix_class = clv_pkg::classify(first_next, second_next);
        result.digit_total  = count_next;
    end

    assign push = take && is_final;

    always_ff @(posedge aclk) begin
        if (!aresetn || push) begin
            count_reg    <= '0;
            sum_even_reg <= '0;
            sum_odd_reg  <= '0;
            first_reg    <= '0;
            second_reg   <= '0;
            bad_reg      <= 1'b0;
        end else if (take) begin
            count_reg    <= count_next;
            sum_even_reg <= sum_even_next;
            sum_odd_reg  <= sum_odd_next;
            first_reg    <= first_next;
            second_reg   <= second_next;
            bad_reg      <= bad_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/clv_out_buf.sv
`default_nettype none

`include "card_number_luhn_validator_assert.svh"

// Result register with a skid word behind it.
module clv_out_buf (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           push,
    input  wire clv_pkg::result_t               push_word,
    output logic                                in_ready,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output clv_pkg::result_t                    out_word
);

    logic             main_valid_reg;
    logic             skid_valid_reg;
    clv_pkg::result_t main_reg;
    clv_pkg::result_t skid_reg;
    logic             pop;

    assign pop       = main_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_word  = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!main_valid_reg || pop) begin
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= push;
            end else begin
                main_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!main_valid_reg || pop) begin
            if (skid_valid_reg) begin
                main_reg <= skid_reg;
                if (push) begin
                    skid_reg <= push_word;
                end
            end else if (push) begin
                main_reg <= push_word;
            end
        end else if (push) begin
            skid_reg <= push_word;
        end
    end

    `CLV_ASSERT_ANY(a_skid_behind_main, aclk, skid_valid_reg |-> main_valid_reg, "skid word without head word")
    `CLV_ASSERT_RST(a_no_push_when_full, aclk, aresetn, !(push && skid_valid_reg), "word pushed into full buffer")
    `CLV_ASSERT_RST(a_drain_empties, aclk, aresetn, (pop && !skid_valid_reg && !push) |=> !main_valid_reg, "buffer not empty after last word taken")
    `CLV_ASSERT_RST(a_skid_moves_up, aclk, aresetn, (pop && skid_valid_reg) |=> (main_valid_reg && main_reg == $past(skid_reg)), "skid word lost")

endmodule

`default_nettype wire

### hw/rtl/card_number_luhn_validator.sv
`default_nettype none

// A result word is registered into the head register, or the skid word behind a waiting result.
// Throughput: one character per cycle while s_tready is high; the sums are registered.
// A result may wait for m_tready while the next number streams in; input stalls
// only when two results are waiting (head register plus skid word).
// Reset (aresetn low, synchronous) clears all sums and counts, empties the output
// and sets min_digits to 13 and max_digits to 19.
module card_number_luhn_validator (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [7:0]                        s_tdata,   // [7:0] char_code
    input  wire logic                              s_tlast,   // is_final
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [15:0]                            m_tdata,   // [1:0] status, [4:2] prefix_class,
                                                              // [9:5] digit_total, rest zero
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [clv_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [clv_pkg::CFG_DATA_W-1:0]    cfg_data
);

    clv_pkg::cfg_t    cfg_reg;
    clv_pkg::result_t result;
    clv_pkg::result_t out_word;
    logic             push;
    logic             take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_digits <= clv_pkg::MIN_DIGITS_RESET;
            cfg_reg.max_digits <= clv_pkg::MAX_DIGITS_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                clv_pkg::CFG_IDX_MIN: cfg_reg.min_digits <= cfg_data;
                clv_pkg::CFG_IDX_MAX: cfg_reg.max_digits <= cfg_data;
                default: ;
            endcase
        end
    end

    assign take = s_tvalid && s_tready;

    clv_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (take),
        .char_code (s_tdata),
        .is_final  (s_tlast),
        .cfg       (cfg_reg),
        .push      (push),
        .result    (result)
    );

    clv_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_word (result),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word)
    );

    assign m_tdata = {(16 - clv_pkg::RESULT_W)'(0), out_word};

endmodule

`default_nettype wire
